@@ hdl/gaussian_kernel_density_sum_core_assert.svh @@
// Assertion macros for the Gaussian kernel density sum core.
// Included by the top level; needs no package.
`ifndef GAUSSIAN_KERNEL_DENSITY_SUM_CORE_ASSERT_SVH
`define GAUSSIAN_KERNEL_DENSITY_SUM_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define GKDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define GKDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/gkds_pkg.sv @@
// Package for the Gaussian kernel density sum core: sizes, types and the exp table.
// Used by every module of the block; depends on nothing.
package gkds_pkg;

    localparam int DIMENSIONS      = 2;
    localparam int MAX_POINTS      = 1024;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int LANES           = 2;
    localparam int PT_AW           = $clog2(MAX_POINTS);
    localparam int ROWS            = MAX_POINTS / LANES;
    localparam int ROW_AW          = $clog2(ROWS);
    localparam int LANE_AW         = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int EXP_AW          = $clog2(EXP_TABLE_DEPTH);
    localparam int CNT_W           = 11;
    localparam int COORD_W         = 16;
    localparam int ACC_W           = 48;

    localparam logic [1:0] REG_INV_BW = 2'd0;
    localparam logic [1:0] REG_POINTS = 2'd1;
    localparam logic [1:0] REG_NORM   = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [DIMENSIONS-1:0] t_coords;

    typedef struct packed {
        logic mode;
        logic [9:0] point_index;
        logic signed [15:0] coord_0;
        logic signed [15:0] coord_1;
        logic signed [15:0] coord_2;
        logic signed [15:0] coord_3;
        logic [15:0] sample_weight;
    } t_in_item;

    typedef struct packed {
        logic [31:0] density;
        logic saturated;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [31:0] data;
    } t_cfg_item;

    // Lane control: a row read was issued, and which row entries count.
    typedef struct packed {
        logic valid;
        logic [LANES-1:0] use_lane;
    } t_lane_ctl;

    function automatic logic [15:0] exp_entry(input int i);
        logic [63:0] x, y, e, t;
        logic [127:0] w;
        x = (64'(i) << 36) / 64'(EXP_TABLE_DEPTH);
        y = x >> 6;
        e = 64'h1_0000_0000;
        t = 64'h1_0000_0000;
        for (int n = 1; n <= 10; n++) begin
            w = 128'(t) * 128'(y);
            t = 64'(w >> 32) / 64'(n);
            if (n % 2 == 1) e = e - t; else e = e + t;
        end
        for (int k = 0; k < 6; k++) begin
            if (e < 64'h1_0000_0000) begin
                w = 128'(e) * 128'(e) + 128'h8000_0000;
                e = 64'(w >> 32);
            end
        end
        return 16'((e + 64'h8000) >> 16);
    endfunction

    typedef logic [16:0] t_exp_tab [EXP_TABLE_DEPTH];

    function automatic t_exp_tab build_exp();
        t_exp_tab tab;
        logic [63:0] x, y, e, t;
        logic [127:0] w;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            x = (64'(i) << 36) / 64'(EXP_TABLE_DEPTH);
            y = x >> 6;
            e = 64'h1_0000_0000;
            t = 64'h1_0000_0000;
            for (int n = 1; n <= 10; n++) begin
                w = 128'(t) * 128'(y);
                t = 64'(w >> 32) / 64'(n);
                if (n % 2 == 1) e = e - t; else e = e + t;
            end
            for (int k = 0; k < 6; k++) begin
                if (e < 64'h1_0000_0000) begin
                    w = 128'(e) * 128'(e) + 128'h8000_0000;
                    e = 64'(w >> 32);
                end
            end
            tab[i] = 17'((e + 64'h8000) >> 16);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp();

endpackage

@@ hdl/gkds_if.sv @@
// Valid/ready channel interface for the Gaussian kernel density sum core.
// Payload type is a parameter of the interface; no package dependency.
interface gkds_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/gkds_lane.sv @@
// One kernel lane: distance, scaling, table lookup and weighting for one stored point.
// Depends on gkds_pkg.
module gkds_lane
    import gkds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_coords     i_query,
    input  t_coords     i_point,
    input  logic [15:0] i_weight,
    input  logic [15:0] i_inv_bw,
    output logic [32:0] o_term
);
    logic [16:0] n_mag [DIMENSIONS];
    logic [16:0] r_mag [DIMENSIONS];
    logic [32:0] n_prod [DIMENSIONS];
    logic [24:0] r_s [DIMENSIONS];
    logic [15:0] r_w1, r_w2, r_w3, r_w4;
    logic [50:0] n_r2;
    logic [31:0] r_r2;
    logic [EXP_AW:0] n_idx;
    logic [42:0] n_scaled;
    logic [16:0] r_kern;
    logic [32:0] r_term;

    always_comb begin
        logic signed [16:0] d;
        for (int k = 0; k < DIMENSIONS; k++) begin
            d = 17'(i_query[k]) - 17'(i_point[k]);
            n_mag[k] = d[16] ? 17'(-d) : 17'(d);
            n_prod[k] = 33'(r_mag[k]) * 33'(i_inv_bw);
        end
    end

    always_comb begin
        n_r2 = '0;
        for (int k = 0; k < DIMENSIONS; k++) begin
            n_r2 = n_r2 + 51'(50'(r_s[k]) * 50'(r_s[k]));
        end
    end

    always_comb begin
        logic [31:0] a;
        a = r_r2 >> 1;
        n_scaled = (43'(a) * 43'(EXP_TABLE_DEPTH) + 43'(1 << 19)) >> 20;
        n_idx = (n_scaled >= 43'(EXP_TABLE_DEPTH)) ? (EXP_AW+1)'(EXP_TABLE_DEPTH)
                                                   : (EXP_AW+1)'(n_scaled);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIMENSIONS; k++) begin
                r_mag[k] <= n_mag[k];
                r_s[k] <= 25'(n_prod[k] >> 8);
            end
            r_w1 <= i_weight;
            r_w2 <= r_w1;
            r_w3 <= r_w2;
            r_w4 <= r_w3;
            r_r2 <= (n_r2 > 51'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(n_r2);
            r_kern <= n_idx[EXP_AW] ? 17'd0 : EXP_TAB[n_idx[EXP_AW-1:0]];
            r_term <= 33'(r_kern) * 33'(r_w4);
        end
    end

    assign o_term = r_term;
endmodule

@@ hdl/gkds_merge.sv @@
// Merge stage: adds the lane terms into the saturating accumulator and scales the result.
// Depends on gkds_pkg.
module gkds_merge
    import gkds_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_term_valid,
    input  logic [LANES-1:0]        i_term_use,
    input  logic [LANES-1:0][32:0]  i_terms,
    input  logic                    i_finish,
    input  logic [31:0]             i_norm,
    output logic                    o_done,
    output t_out_item               o_result
);
    logic [ACC_W-1:0] r_acc;
    logic r_sat;
    logic [ACC_W+LANE_AW:0] n_sum;
    logic [1:0] r_fin;
    logic [63:0] r_p1, r_p0;
    logic r_done;
    t_out_item r_result;

    always_comb begin
        n_sum = (ACC_W+LANE_AW+1)'(r_acc);
        for (int l = 0; l < LANES; l++) begin
            if (i_term_use[l]) n_sum = n_sum + (ACC_W+LANE_AW+1)'(i_terms[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= '0;
            r_done <= 1'b0;
        end else begin
            r_fin <= {r_fin[0], i_finish};
            r_done <= r_fin[1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [64:0] res;
        if (i_clear) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_term_valid) begin
            if (n_sum > (ACC_W+LANE_AW+1)'({ACC_W{1'b1}})) begin
                r_acc <= '1;
                r_sat <= 1'b1;
            end else begin
                r_acc <= ACC_W'(n_sum);
            end
        end
        if (r_fin[0]) begin
            r_p1 <= 64'(r_acc[ACC_W-1:16]) * 64'(i_norm);
            r_p0 <= 64'(r_acc[15:0]) * 64'(i_norm);
        end
        if (r_fin[1]) begin
            res = (65'(r_p1) + 65'(r_p0 >> 16)) >> 16;
            if (res > 65'hFFFF_FFFF) begin
                r_result.density <= 32'hFFFF_FFFF;
                r_result.saturated <= 1'b1;
            end else begin
                r_result.density <= 32'(res);
                r_result.saturated <= r_sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_result = r_result;
endmodule

@@ hdl/gaussian_kernel_density_sum_core.sv @@
// Gaussian kernel density direct-sum core, top level.
// Channels: i_in (load or query transaction), o_out (density result), i_cfg (register writes).
// A load transaction writes one point and weight into the point store and gives no result.
// A query transaction reads the store two points per cycle through two kernel lanes;
// the merge stage sums the lanes' weighted kernels into a saturating 48-bit accumulator
// and scales by norm_scale. A query's duration is set by the one row read per cycle
// from the point store.
// A load leaves the core idle and ready for the next item.
// Items are processed one at a time; input ready is low while a query is in flight or
// while its result waits in the output register.
// Reset sets the registers to their defaults and clears the state machine and valid flags; the point store
// is not cleared, and a query over slots never loaded gives undefined values.
// If the receiver stalls, the result holds in the output register until taken.
module gaussian_kernel_density_sum_core
    import gkds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gkds_if.sink   i_in,
    gkds_if.sink   i_cfg,
    gkds_if.source o_out
);
    `include "gaussian_kernel_density_sum_core_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state r_state;
    logic [15:0] r_inv_bw;
    logic [CNT_W-1:0] r_points;
    logic [31:0] r_norm;
    t_coords r_query;
    logic [CNT_W-1:0] r_count, r_pos;
    logic [3:0] r_drain;
    logic r_finish_sent;
    t_lane_ctl r_ctl0, r_ctl1;
    logic [3:0][LANES-1:0] r_use;
    logic [3:0] r_vld;
    logic [LANES-1:0][32:0] w_terms;
    logic w_done;
    t_out_item w_result;
    logic r_out_valid;
    t_out_item r_out;

    logic [DIMENSIONS*COORD_W+16-1:0] r_mem [LANES][ROWS];
    logic [DIMENSIONS*COORD_W+16-1:0] r_rd [LANES];

    t_in_item in_d;
    logic in_fire, cfg_fire, issue;
    t_coords in_coords;

    assign in_d = i_in.data;
    assign in_fire = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        logic signed [15:0] c [4];
        c[0] = in_d.coord_0;
        c[1] = in_d.coord_1;
        c[2] = in_d.coord_2;
        c[3] = in_d.coord_3;
        for (int k = 0; k < DIMENSIONS; k++) in_coords[k] = c[k];
    end

    assign issue = (r_state == ST_RUN) && (r_pos < r_count);

    always_ff @(posedge i_clk) begin
        logic [PT_AW-1:0] ix;
        ix = in_d.point_index[PT_AW-1:0];
        for (int l = 0; l < LANES; l++) begin
            if (in_fire && !in_d.mode && (LANES == 1 || LANE_AW'(ix) == LANE_AW'(l))) begin
                r_mem[l][ROW_AW'(ix >> LANE_AW)] <= {in_coords, in_d.sample_weight};
            end
            if (issue) r_rd[l] <= r_mem[l][ROW_AW'(r_pos >> LANE_AW)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_bw <= 16'd256;
            r_points <= '0;
            r_norm <= 32'd65536;
        end else if (cfg_fire) begin
            case (i_cfg.data.index)
                REG_INV_BW: r_inv_bw <= i_cfg.data.data[15:0];
                REG_POINTS: r_points <= i_cfg.data.data[CNT_W-1:0];
                REG_NORM:   r_norm <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctl0 <= '0;
            r_ctl1 <= '0;
            r_vld <= '0;
            r_drain <= '0;
            r_finish_sent <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ctl0.valid <= issue;
            for (int l = 0; l < LANES; l++) begin
                r_ctl0.use_lane[l] <= issue && (r_pos + CNT_W'(l) < r_count);
            end
            r_ctl1 <= r_ctl0;
            r_vld <= {r_vld[2:0], r_ctl1.valid};
            r_finish_sent <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && in_d.mode) begin
                        r_state <= ST_RUN;
                        r_query <= in_coords;
                        r_count <= (r_points > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                   : r_points;
                        r_pos <= '0;
                        r_drain <= '0;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        r_pos <= r_pos + CNT_W'(LANES);
                    end else if (r_drain != 4'd9) begin
                        r_drain <= r_drain + 4'd1;
                    end else begin
                        r_finish_sent <= 1'b1;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_done) r_out_valid <= 1'b1;
                    if (r_out_valid && o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_use <= {r_use[2:0], r_ctl1.use_lane};
        if (w_done) r_out <= w_result;
    end

    logic clear_acc;
    assign clear_acc = in_fire && in_d.mode;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        t_coords pt;
        always_comb begin
            for (int k = 0; k < DIMENSIONS; k++) begin
                pt[k] = r_rd[l][16 + k*COORD_W +: COORD_W];
            end
        end
        gkds_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (1'b1),
            .i_query  (r_query),
            .i_point  (pt),
            .i_weight (r_rd[l][15:0]),
            .i_inv_bw (r_inv_bw),
            .o_term   (w_terms[l])
        );
    end

    gkds_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (clear_acc),
        .i_term_valid (r_vld[3]),
        .i_term_use   (r_use[3]),
        .i_terms      (w_terms),
        .i_finish     (r_finish_sent),
        .i_norm       (r_norm),
        .o_done       (w_done),
        .o_result     (w_result)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;

    `GKDS_ASSERT_IMPL(a_out_only_in_out_state, i_clk, i_rst_n, r_out_valid, r_state == ST_OUT)
    `GKDS_ASSERT_IMPL(a_no_issue_past_count, i_clk, i_rst_n, issue, r_pos < r_count)
    `GKDS_ASSERT_NEXT(a_done_sets_valid, i_clk, i_rst_n, w_done, r_out_valid)
endmodule
